FILE: design/mjs_pkg.sv
// Shared types, constants and helper functions for the multicore job scheduler.
package mjs_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int MAX_CORES   = 8;
  localparam int CORE_W      = 4;
  localparam int CIDX_W      = 3;

  localparam logic [CORE_W-1:0] IDLE_CORE = 4'd15;

  localparam logic [2:0] POL_FCFS     = 3'd0;
  localparam logic [2:0] POL_SJF      = 3'd1;
  localparam logic [2:0] POL_PSJF     = 3'd2;
  localparam logic [2:0] POL_PRIO     = 3'd3;
  localparam logic [2:0] POL_PPRIO    = 3'd4;
  localparam logic [2:0] POL_RR       = 3'd5;

  localparam logic [1:0] ACT_ARRIVE   = 2'd0;
  localparam logic [1:0] ACT_FINISH   = 2'd1;
  localparam logic [1:0] ACT_EXPIRE   = 2'd2;
  localparam logic [1:0] ACT_NOP      = 2'd3;

  localparam logic CFG_POLICY = 1'b0;
  localparam logic CFG_CORES  = 1'b1;

  typedef struct packed {
    logic [15:0]       job;
    logic [15:0]       prio;
    logic [31:0]       rem;
    logic [31:0]       started;
    logic [CORE_W-1:0] core;
  } entry_t;

  // Charge a running entry for the ticks it has run since its last start.
  function automatic entry_t bring_up(entry_t e, logic [31:0] now);
    entry_t      r;
    logic [31:0] ran;
    r   = e;
    ran = now - e.started;
    if (e.core != IDLE_CORE) begin
      r.rem     = (ran >= e.rem) ? 32'd0 : e.rem - ran;
      r.started = now;
    end
    return r;
  endfunction

  // True when record a goes ahead of table entry b under the policy.
  function automatic logic rank_before(logic [2:0] pol, entry_t a, entry_t b);
    logic [31:0] ka;
    logic [31:0] kb;
    logic        ordered;
    ordered = 1'b1;
    ka      = a.rem;
    kb      = b.rem;
    priority if (pol == POL_SJF || pol == POL_PSJF) begin
      ka = a.rem;
      kb = b.rem;
    end else if (pol == POL_PRIO || pol == POL_PPRIO) begin
      ka = {16'd0, a.prio};
      kb = {16'd0, b.prio};
    end else begin
      ordered = 1'b0;
    end
    if (!ordered) return 1'b0;
    if (ka != kb) return ka < kb;
    return a.job < b.job;
  endfunction

endpackage

FILE: design/mjs_mem.sv
// Two-bank entry table: one write port, one registered read port.
module mjs_mem
  import mjs_pkg::*;
(
  input  logic             clk,
  input  logic             re,
  input  logic [IDX_W:0]   raddr,
  output entry_t           rdata,
  input  logic             we,
  input  logic [IDX_W:0]   waddr,
  input  entry_t           wdata
);

  entry_t mem [2*TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

FILE: design/multicore_job_scheduler.sv
// Multicore job scheduler: ordered job table in a two-bank memory, one event at a time.
//
// Events enter on the evt channel (evt_valid / evt_stall); each event gives exactly one
// result on the res channel (res_valid / res_stall). Policy and core count go in through
// cfg_we / cfg_index / cfg_data by the user only while the block is idle (unchecked).
// The table lives in one memory with two banks. Every event copies the table from the
// current bank to the other one, entry by entry, bringing running jobs up to time_now,
// dropping a removed entry and inserting a new or requeued one on the way; the banks
// then swap. A finish or expiry first runs a scan pass over the table to find the entry.
// The memory's single read port gives one entry per cycle, held while an insertion is
// written. A new event is taken only once the previous one is finished; the result
// register lets the next event start while a result still waits on a stalled receiver,
// but the block holds in its final step until that register is free.
// Reset (synchronous, rst high) empties the table, idles all cores, sets the policy to
// first come first served and the core count to one. Memory contents are not cleared.
module multicore_job_scheduler
  import mjs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  logic [1:0]  action,
  input  logic [15:0] job_id,
  input  logic [31:0] time_now,
  input  logic [31:0] run_length,
  input  logic [15:0] job_priority,
  input  logic [2:0]  core_index,
  output logic        res_valid,
  input  logic        res_stall,
  output logic        change,
  output logic [2:0]  chosen_core,
  output logic [15:0] chosen_job,
  output logic        table_full,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_COPY = 6'b000100,
    S_FIX  = 6'b001000,
    S_FIX2 = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state;
  logic [2:0]            policy;
  logic [3:0]            ccount;
  logic [CNT_W-1:0]      count;
  logic [MAX_CORES-1:0]  busy;
  logic                  bank;

  logic [1:0]            ev_act;
  logic [15:0]           ev_id;
  logic [31:0]           ev_now;
  logic [CIDX_W-1:0]     ev_core;

  logic [CNT_W-1:0]      ra;
  logic                  rvalid;
  logic [IDX_W-1:0]      ridx;
  logic [CNT_W-1:0]      wa;

  logic                  match_found;
  logic [IDX_W-1:0]      match_idx;
  entry_t                match_rec;
  logic                  ins_pend;
  logic                  ins_idle;
  entry_t                ins_rec;
  logic [IDX_W-1:0]      ins_pos;
  logic                  wait_found;
  logic [IDX_W-1:0]      wait_pos;
  entry_t                wait_rec;
  logic                  run_found;
  logic [IDX_W-1:0]      run_pos;
  entry_t                run_rec;

  logic                  w_change;
  logic [2:0]            w_core;
  logic [15:0]           w_job;
  logic                  w_full;

  logic                  mem_re;
  logic [IDX_W:0]        mem_raddr;
  entry_t                mem_rdata;
  logic                  mem_we;
  logic [IDX_W:0]        mem_waddr;
  entry_t                mem_wdata;

  logic [3:0]            act_n;
  logic                  free_found;
  logic [CIDX_W-1:0]     free_core;
  entry_t                upd;
  logic                  skip;
  logic                  ins_first;
  logic                  adv;
  logic                  tail;
  logic                  cp_we;
  entry_t                cp_rec;
  logic                  cp_ins;
  logic                  preempt_go;
  logic                  disp_go;
  logic                  evt_take;
  logic                  arr_ok;
  logic                  arr_place;

  mjs_mem u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  assign evt_stall = (state != S_IDLE);
  assign evt_take  = evt_valid && !evt_stall;

  always_comb begin
    if (ccount == 4'd0) begin
      act_n = 4'd1;
    end else if (ccount > 4'(MAX_CORES)) begin
      act_n = 4'(MAX_CORES);
    end else begin
      act_n = ccount;
    end
  end

  // Lowest idle core among the active ones.
  always_comb begin
    free_found = 1'b0;
    free_core  = '0;
    for (int i = 0; i < MAX_CORES; i++) begin
      if (!free_found && (4'(i) < act_n) && !busy[i]) begin
        free_found = 1'b1;
        free_core  = CIDX_W'(i);
      end
    end
  end

  assign arr_ok    = (action == ACT_ARRIVE) && (count < CNT_W'(TABLE_DEPTH));
  assign arr_place = arr_ok && free_found;

  assign upd       = bring_up(mem_rdata, ev_now);
  assign skip      = match_found && (ridx == match_idx);
  assign ins_first = ins_pend && rank_before(policy, ins_rec, upd);
  assign tail      = !rvalid && (ra >= count);

  always_comb begin
    cp_we  = 1'b0;
    cp_rec = upd;
    cp_ins = 1'b0;
    adv    = 1'b1;
    if (state == S_COPY) begin
      if (rvalid) begin
        if (skip) begin
          adv = 1'b1;
        end else if (ins_first) begin
          cp_we  = 1'b1;
          cp_rec = ins_rec;
          cp_ins = 1'b1;
          adv    = 1'b0;
        end else begin
          cp_we = 1'b1;
        end
      end else if (tail && ins_pend) begin
        cp_we  = 1'b1;
        cp_rec = ins_rec;
        cp_ins = 1'b1;
      end
    end
  end

  assign preempt_go = ins_idle && (policy == POL_PSJF || policy == POL_PPRIO)
                      && ({1'b0, ins_pos} < CNT_W'(act_n)) && run_found;
  assign disp_go    = (ev_act == ACT_FINISH || ev_act == ACT_EXPIRE)
                      && ({1'b0, ev_core} < act_n) && !busy[ev_core] && wait_found;

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = {bank, ra[IDX_W-1:0]};
    unique case (state)
      S_SCAN: mem_re = (ra < count);
      S_COPY: mem_re = adv && (ra < count);
      default: mem_re = 1'b0;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {~bank, wa[IDX_W-1:0]};
    mem_wdata = cp_rec;
    unique case (state)
      S_COPY: mem_we = cp_we;
      S_FIX: begin
        if (preempt_go) begin
          mem_we         = 1'b1;
          mem_waddr      = {~bank, run_pos};
          mem_wdata      = run_rec;
          mem_wdata.core = IDLE_CORE;
        end else if (disp_go) begin
          mem_we            = 1'b1;
          mem_waddr         = {~bank, wait_pos};
          mem_wdata         = wait_rec;
          mem_wdata.core    = {1'b0, ev_core};
          mem_wdata.started = ev_now;
        end
      end
      S_FIX2: begin
        mem_we            = 1'b1;
        mem_waddr         = {~bank, ins_pos};
        mem_wdata         = ins_rec;
        mem_wdata.core    = run_rec.core;
        mem_wdata.started = ev_now;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy <= POL_FCFS;
      ccount <= 4'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_POLICY: policy <= cfg_data[2:0];
        CFG_CORES:  ccount <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      busy        <= '0;
      bank        <= 1'b0;
      rvalid      <= 1'b0;
      res_valid   <= 1'b0;
      ins_pend    <= 1'b0;
      ins_idle    <= 1'b0;
      match_found <= 1'b0;
      wait_found  <= 1'b0;
      run_found   <= 1'b0;
    end else begin
      if (res_valid && !res_stall && state != S_DONE) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (evt_take) begin
            ev_act      <= action;
            ev_id       <= job_id;
            ev_now      <= time_now;
            ev_core     <= core_index;
            ra          <= '0;
            wa          <= '0;
            rvalid      <= 1'b0;
            match_found <= 1'b0;
            wait_found  <= 1'b0;
            run_found   <= 1'b0;
            ins_pend    <= arr_ok;
            ins_idle    <= arr_ok && !free_found;
            w_change    <= arr_place;
            w_core      <= arr_place ? free_core : '0;
            w_job       <= arr_place ? job_id : '0;
            w_full      <= (action == ACT_ARRIVE) && !arr_ok;
            ins_rec     <= '{job: job_id, prio: job_priority, rem: run_length,
                             started: time_now,
                             core: free_found ? {1'b0, free_core} : IDLE_CORE};
            if (arr_place) busy[free_core] <= 1'b1;
            unique case (action)
              ACT_FINISH, ACT_EXPIRE: state <= S_SCAN;
              default: state <= S_COPY;
            endcase
          end
        end

        S_SCAN: begin
          if (ra < count) begin
            ra     <= ra + 1'b1;
            ridx   <= ra[IDX_W-1:0];
            rvalid <= 1'b1;
          end else begin
            rvalid <= 1'b0;
          end
          if (rvalid && !match_found &&
              ((ev_act == ACT_FINISH) ? (upd.job == ev_id) : (upd.core == {1'b0, ev_core})))
          begin
            match_found <= 1'b1;
            match_idx   <= ridx;
            match_rec   <= upd;
          end
          if (tail) begin
            ra    <= '0;
            state <= S_COPY;
            if (match_found) begin
              if (match_rec.core < CORE_W'(MAX_CORES)) begin
                busy[match_rec.core[CIDX_W-1:0]] <= 1'b0;
              end
              if (ev_act == ACT_EXPIRE) begin
                ins_pend <= 1'b1;
                ins_rec  <= '{job: match_rec.job, prio: match_rec.prio,
                              rem: match_rec.rem, started: ev_now, core: IDLE_CORE};
              end
            end
          end
        end

        S_COPY: begin
          if (adv && (ra < count)) begin
            ra     <= ra + 1'b1;
            ridx   <= ra[IDX_W-1:0];
            rvalid <= 1'b1;
          end else if (adv) begin
            rvalid <= 1'b0;
          end
          if (cp_we) begin
            wa <= wa + 1'b1;
            if (cp_rec.core == IDLE_CORE) begin
              if (!wait_found) begin
                wait_found <= 1'b1;
                wait_pos   <= wa[IDX_W-1:0];
                wait_rec   <= cp_rec;
              end
            end else begin
              run_found <= 1'b1;
              run_pos   <= wa[IDX_W-1:0];
              run_rec   <= cp_rec;
            end
          end
          if (cp_ins) begin
            ins_pend <= 1'b0;
            ins_pos  <= wa[IDX_W-1:0];
          end
          if (tail && !ins_pend) state <= S_FIX;
        end

        S_FIX: begin
          count <= wa;
          if (preempt_go) begin
            w_change <= 1'b1;
            w_core   <= run_rec.core[CIDX_W-1:0];
            w_job    <= ev_id;
            state    <= S_FIX2;
          end else begin
            if (disp_go) begin
              busy[ev_core] <= 1'b1;
              w_change      <= 1'b1;
              w_core        <= ev_core;
              w_job         <= wait_rec.job;
            end
            state <= S_DONE;
          end
        end

        S_FIX2: state <= S_DONE;

        S_DONE: begin
          if (!res_valid || !res_stall) begin
            res_valid   <= 1'b1;
            change      <= w_change;
            chosen_core <= w_core;
            chosen_job  <= w_job;
            table_full  <= w_full;
            bank        <= ~bank;
            state       <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("table count beyond depth");

  a_full_no_change: assert property (@(posedge clk) disable iff (rst)
    res_valid && table_full |-> !change)
    else $error("dropped arrival reported a placement");

  a_write_ahead: assert property (@(posedge clk) disable iff (rst)
    state == S_COPY |-> wa <= ra + 1'b1)
    else $error("copy pass wrote more entries than it read");

  a_dispatch_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_FIX && !preempt_go && disp_go |=> busy[$past(ev_core)])
    else $error("dispatched core not marked busy");
`endif

endmodule
